FILE: rtl/qts_pkg.sv
// Package for the quoted token splitter: state codes, queue command type,
// the escape table and the counter helpers. Depends on nothing.
package qts_pkg;

    // Width of the internal token counter, saturating at all ones.
    localparam int COUNT_BITS = 16;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes the splitter reacts to.
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_ESCAPE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        QT_NONE   = 2'd0,
        QT_DOUBLE = 2'd1,
        QT_SINGLE = 2'd2
    } t_quote;

    // What the back has to emit for one item.
    typedef enum logic [2:0] {
        CK_BYTE         = 3'd0, // one token byte
        CK_BYTE_PAIR    = 3'd1, // a backslash, then the token byte
        CK_TOKEN_END    = 3'd2, // token end mark
        CK_STRING_END   = 3'd3, // string end with count
        CK_TOKEN_STRING = 3'd4  // token end mark, then string end with count
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data;
        logic [15:0] count;
    } t_cmd;

    // Escape translation; letters outside the table give a zero byte.
    function automatic logic [7:0] esc_lookup(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h5C:   r = 8'h5C;
            8'h22:   r = 8'h22;
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        if (v == {COUNT_BITS{1'b1}}) begin
            r = v;
        end else begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    // Clamp the counter to the 16-bit reported range.
    function automatic logic [15:0] count_report(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        logic [15:0] r;
        w = 32'(v);
        if (w > 32'h0000_FFFF) begin
            r = 16'hFFFF;
        end else begin
            r = w[15:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/qts_if.sv
// Channel interfaces of the quoted token splitter: raw byte input and
// token result output. Depends on nothing.
interface qts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_end;

    modport source (output valid, output in_byte, output is_end, input ready);
    modport sink   (input valid, input in_byte, input is_end, output ready);
endinterface

interface qts_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        token_end;
    logic        string_end;
    logic [15:0] tokens_seen;
    logic        last_of_run;

    modport source (output valid, output out_byte, output byte_valid, output token_end,
                    output string_end, output tokens_seen, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input token_end,
                    input string_end, input tokens_seen, input last_of_run,
                    output ready);
endinterface

FILE: rtl/qts_front.sv
// Front of the quoted token splitter: accepts bytes, tracks token state and
// pushes one command per item that causes results. Depends on qts_pkg, qts_if.
module qts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qts_in_if.sink            i_in,
    input  logic              i_queue_full,
    output logic              o_push,
    output qts_pkg::t_cmd     o_cmd
);

    qts_pkg::t_phase                  r_phase, n_phase;
    qts_pkg::t_quote                  r_quote, n_quote;
    logic [qts_pkg::COUNT_BITS-1:0]   r_count, n_count;

    logic       accept;
    logic [7:0] c;
    logic       is_ws;
    logic       is_bs;
    logic       is_quote;
    logic       tok_close;
    logic       cmd_valid;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && !i_queue_full;
    assign c          = i_in.in_byte;
    assign is_ws      = (c == qts_pkg::CHR_SPACE) || (c == qts_pkg::CHR_TAB);
    assign is_bs      = (c == qts_pkg::CHR_BACKSLASH);
    assign is_quote   = (c == qts_pkg::CHR_DQUOTE) || (c == qts_pkg::CHR_SQUOTE);

    // Inside an open token: the matching quote closes a quoted token, and
    // whitespace closes an unquoted one.
    always_comb begin
        unique case (r_quote)
            qts_pkg::QT_DOUBLE: tok_close = (c == qts_pkg::CHR_DQUOTE);
            qts_pkg::QT_SINGLE: tok_close = (c == qts_pkg::CHR_SQUOTE);
            default:            tok_close = is_ws;
        endcase
    end

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_quote = r_quote;
        n_count = r_count;
        if (accept) begin
            if (i_in.is_end) begin
                n_phase = qts_pkg::PH_IDLE;
                n_quote = qts_pkg::QT_NONE;
                n_count = '0;
            end else begin
                unique case (r_phase)
                    qts_pkg::PH_ESCAPE: begin
                        n_phase = qts_pkg::PH_TOKEN;
                    end
                    qts_pkg::PH_TOKEN: begin
                        if (tok_close) begin
                            n_phase = qts_pkg::PH_IDLE;
                            n_quote = qts_pkg::QT_NONE;
                            n_count = qts_pkg::count_inc(r_count);
                        end else if (is_bs) begin
                            n_phase = qts_pkg::PH_ESCAPE;
                        end
                    end
                    default: begin
                        n_phase = qts_pkg::PH_IDLE;
                        if (is_ws) begin
                            n_phase = qts_pkg::PH_IDLE;
                        end else if (c == qts_pkg::CHR_DQUOTE) begin
                            n_phase = qts_pkg::PH_TOKEN;
                            n_quote = qts_pkg::QT_DOUBLE;
                        end else if (c == qts_pkg::CHR_SQUOTE) begin
                            n_phase = qts_pkg::PH_TOKEN;
                            n_quote = qts_pkg::QT_SINGLE;
                        end else begin
                            n_quote = qts_pkg::QT_NONE;
                            n_phase = is_bs ? qts_pkg::PH_ESCAPE : qts_pkg::PH_TOKEN;
                        end
                    end
                endcase
            end
        end
    end

    // Command for the back.
    always_comb begin
        cmd_valid   = 1'b0;
        o_cmd.kind  = qts_pkg::CK_BYTE;
        o_cmd.data  = c;
        o_cmd.count = '0;
        if (i_in.is_end) begin
            cmd_valid = 1'b1;
            if (r_phase == qts_pkg::PH_TOKEN || r_phase == qts_pkg::PH_ESCAPE) begin
                o_cmd.kind  = qts_pkg::CK_TOKEN_STRING;
                o_cmd.count = qts_pkg::count_report(qts_pkg::count_inc(r_count));
            end else begin
                o_cmd.kind  = qts_pkg::CK_STRING_END;
                o_cmd.count = qts_pkg::count_report(r_count);
            end
        end else begin
            unique case (r_phase)
                qts_pkg::PH_ESCAPE: begin
                    cmd_valid = 1'b1;
                    if (c[7]) begin
                        o_cmd.kind = qts_pkg::CK_BYTE_PAIR;
                    end else begin
                        o_cmd.data = qts_pkg::esc_lookup(c);
                    end
                end
                qts_pkg::PH_TOKEN: begin
                    if (tok_close) begin
                        cmd_valid  = 1'b1;
                        o_cmd.kind = qts_pkg::CK_TOKEN_END;
                    end else begin
                        cmd_valid = !is_bs;
                    end
                end
                default: begin
                    cmd_valid = !(is_ws || is_quote || is_bs);
                end
            endcase
        end
    end

    assign o_push = accept && cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= qts_pkg::PH_IDLE;
            r_quote <= qts_pkg::QT_NONE;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_quote <= n_quote;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/qts_queue.sv
// Short command queue between the front and the back of the quoted token
// splitter. Depends on qts_pkg.
module qts_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  qts_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output qts_pkg::t_cmd     o_head
);

    qts_pkg::t_cmd                 r_mem [qts_pkg::QUEUE_DEPTH];
    logic [qts_pkg::QUEUE_AW-1:0]  r_wr, n_wr;
    logic [qts_pkg::QUEUE_AW-1:0]  r_rd, n_rd;
    logic [qts_pkg::QUEUE_AW:0]    r_fill, n_fill;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_fill == (qts_pkg::QUEUE_AW + 1)'(qts_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr   = do_push ? r_wr + 1'b1 : r_wr;
        n_rd   = do_pop ? r_rd + 1'b1 : r_rd;
        n_fill = r_fill;
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/qts_back.sv
// Back of the quoted token splitter: expands queued commands into one or
// two result items into the output register. Depends on qts_pkg, qts_if.
module qts_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  qts_pkg::t_cmd     i_head,
    output logic              o_pop,
    qts_out_if.source         o_out
);

    logic        r_valid, n_valid;
    logic        r_sub, n_sub;
    logic [7:0]  r_byte, n_byte;
    logic        r_bv, n_bv;
    logic        r_te, n_te;
    logic        r_se, n_se;
    logic [15:0] r_cnt, n_cnt;
    logic        r_last, n_last;
    logic        load;
    logic        two;

    assign two  = (i_head.kind == qts_pkg::CK_BYTE_PAIR) ||
                  (i_head.kind == qts_pkg::CK_TOKEN_STRING);
    assign load = !i_empty && (!r_valid || o_out.ready);
    assign o_pop = load && (!two || r_sub);

    always_comb begin
        n_valid = r_valid && !o_out.ready;
        n_sub   = r_sub;
        n_byte  = r_byte;
        n_bv    = r_bv;
        n_te    = r_te;
        n_se    = r_se;
        n_cnt   = r_cnt;
        n_last  = r_last;
        if (load) begin
            n_valid = 1'b1;
            n_sub   = two && !r_sub;
            n_byte  = 8'h00;
            n_bv    = 1'b0;
            n_te    = 1'b0;
            n_se    = 1'b0;
            n_cnt   = 16'h0000;
            n_last  = !two || r_sub;
            unique case (i_head.kind)
                qts_pkg::CK_BYTE: begin
                    n_byte = i_head.data;
                    n_bv   = 1'b1;
                end
                qts_pkg::CK_BYTE_PAIR: begin
                    n_byte = r_sub ? i_head.data : qts_pkg::CHR_BACKSLASH;
                    n_bv   = 1'b1;
                end
                qts_pkg::CK_TOKEN_END: begin
                    n_te = 1'b1;
                end
                qts_pkg::CK_STRING_END: begin
                    n_se  = 1'b1;
                    n_cnt = i_head.count;
                end
                qts_pkg::CK_TOKEN_STRING: begin
                    n_te  = !r_sub;
                    n_se  = r_sub;
                    n_cnt = r_sub ? i_head.count : 16'h0000;
                end
                default: begin
                    n_byte = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_bv   <= n_bv;
        r_te   <= n_te;
        r_se   <= n_se;
        r_cnt  <= n_cnt;
        r_last <= n_last;
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.byte_valid  = r_bv;
    assign o_out.token_end   = r_te;
    assign o_out.string_end  = r_se;
    assign o_out.tokens_seen = r_cnt;
    assign o_out.last_of_run = r_last;

endmodule

FILE: rtl/quoted_token_splitter.sv
// Top level of the quoted token splitter: front, command queue and back.
// Depends on qts_pkg, qts_if, qts_front, qts_queue and qts_back.
//
//   Channel  Dir  Payload                                      Handshake
//   i_in     in   in_byte, is_end                              valid/ready
//   o_out    out  out_byte, byte_valid, token_end, string_end, valid/ready
//                 tokens_seen, last_of_run
//
// The block takes one input item per cycle while the command queue has room.
// An accepted item is written into the command queue and from there loaded
// into the output register. The output delivers one result item per cycle
// while the queue holds commands and the output is ready; an item that
// causes two results (an escaped high byte, or a string end inside a token)
// holds the back for both, and the four-entry queue absorbs that.
// Reset is synchronous and active low; it clears the token state, the
// queue pointers and the output valid. A stall on the output fills the
// queue, and input ready drops only when it is full.
module quoted_token_splitter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qts_in_if.sink    i_in,
    qts_out_if.source o_out
);

    // Front to queue and queue to back.
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    qts_pkg::t_cmd cmd;
    qts_pkg::t_cmd head;

    // The front classifies each byte against the current token state and
    // queues a command only for items that cause results.
    qts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (full),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    // The queue decouples the front from output stalls.
    qts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // The back turns commands into result items, one per cycle unless stalled.
    qts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
